// ===== rtl/core/chemical_formula_tokenizer_defines.svh =====
// Assertion macros shared by the formula tokenizer checkers.
`ifndef CHEMICAL_FORMULA_TOKENIZER_DEFINES_SVH
`define CHEMICAL_FORMULA_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cft check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cft check failed");

`endif

// ===== rtl/core/cft_pkg.sv =====
// Types, constants and character class functions of the formula tokenizer.
package cft_pkg;

	localparam int CFT_MAX_SYMBOL_CHARS = 3;
	localparam int CFT_COUNT_BITS       = 20;

	localparam int CHAR_W     = 8;
	localparam int NAME_W     = 24;
	localparam int NAME_LEN_W = 2;
	localparam int ATOM_W     = 20;

	localparam logic STATUS_TOKEN = 1'b0;
	localparam logic STATUS_ERROR = 1'b1;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SYM,
		PH_CNT,
		PH_ERR
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              first_of_formula;
	} item_t;

	typedef struct packed {
		logic                  status;
		logic [NAME_W-1:0]     element_name;
		logic [NAME_LEN_W-1:0] name_length;
		logic [ATOM_W-1:0]     atom_count;
		logic [CHAR_W-1:0]     bad_char;
	} result_t;

	function automatic logic is_upper(input logic [CHAR_W-1:0] c);
		return (c >= CH_UA) && (c <= CH_UZ);
	endfunction

	function automatic logic is_lower(input logic [CHAR_W-1:0] c);
		return (c >= CH_LA) && (c <= CH_LZ);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== rtl/core/cft_in_if.sv =====
// Character input channel: valid/ready with one formula character.
interface cft_in_if;
	logic                      valid;
	logic                      ready;
	logic [cft_pkg::CHAR_W-1:0] char_code;
	logic                      first_of_formula;

	modport source (output valid, output char_code, output first_of_formula, input ready);
	modport sink (input valid, input char_code, input first_of_formula, output ready);
endinterface

// ===== rtl/core/cft_out_if.sv =====
// Token output channel: valid/ready with one token or error result.
interface cft_out_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [cft_pkg::NAME_W-1:0]     element_name;
	logic [cft_pkg::NAME_LEN_W-1:0] name_length;
	logic [cft_pkg::ATOM_W-1:0]     atom_count;
	logic [cft_pkg::CHAR_W-1:0]     bad_char;

	modport source (output valid, output status, output element_name, output name_length,
		output atom_count, output bad_char, input ready);
	modport sink (input valid, input status, input element_name, input name_length,
		input atom_count, input bad_char, output ready);
endinterface

// ===== rtl/core/cft_in_stage.sv =====
// Input register stage: captures one character transfer per cycle unless the output stage stalls.
module cft_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	cft_in_if.sink        in,
	input  logic          advance,
	output logic          valid_s1,
	output cft_pkg::item_t item_s1
);
	import cft_pkg::*;

	assign in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			item_s1.char_code        <= in.char_code;
			item_s1.first_of_formula <= in.first_of_formula;
		end
	end
endmodule

// ===== rtl/core/cft_parse_core.sv =====
// Parser state and per-character next-state and result logic.
module cft_parse_core #(
	parameter int MAX_SYMBOL_CHARS = cft_pkg::CFT_MAX_SYMBOL_CHARS,
	parameter int COUNT_BITS       = cft_pkg::CFT_COUNT_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cft_pkg::item_t  item_s1,
	input  logic            advance,
	output logic            res_valid,
	output cft_pkg::result_t res
);
	import cft_pkg::*;

	localparam int SYM_W = CHAR_W * MAX_SYMBOL_CHARS;
	localparam int LEN_W = $clog2(MAX_SYMBOL_CHARS + 1);
	localparam int MUL_W = COUNT_BITS + 4;

	phase_t                phase_q, phase_d, phase_cur;
	logic [SYM_W-1:0]      sym_q, sym_d, sym_cur, sym_start, sym_ext;
	logic [LEN_W-1:0]      len_q, len_d, len_cur;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_cur, cnt_next, digit_val, tok_cnt;
	logic [MUL_W-1:0]      cnt_mul;
	logic [NAME_W-1:0]     name_out;
	logic [CHAR_W-1:0]     c;
	logic                  upper, lower, digit, sep;
	logic                  emit_tok, emit_err, tok_use_acc;

	assign c     = item_s1.char_code;
	assign upper = is_upper(c);
	assign lower = is_lower(c);
	assign digit = is_digit(c);
	assign sep   = is_sep(c);

	// first_of_formula clears state before the character is handled
	assign phase_cur = item_s1.first_of_formula ? PH_IDLE : phase_q;
	assign sym_cur   = item_s1.first_of_formula ? '0 : sym_q;
	assign len_cur   = item_s1.first_of_formula ? '0 : len_q;
	assign cnt_cur   = item_s1.first_of_formula ? '0 : cnt_q;

	assign sym_start = {c, {(SYM_W - CHAR_W){1'b0}}};

	always_comb begin
		sym_ext = sym_cur;
		for (int i = 0; i < MAX_SYMBOL_CHARS; i++) begin
			if (len_cur == LEN_W'(i)) begin
				sym_ext[CHAR_W*(MAX_SYMBOL_CHARS-1-i) +: CHAR_W] = c;
			end
		end
	end

	// count * 10 + digit, saturating
	assign digit_val = COUNT_BITS'(c[3:0]);
	assign cnt_mul   = MUL_W'({cnt_cur, 3'b000}) + MUL_W'({cnt_cur, 1'b0}) + MUL_W'(c[3:0]);
	assign cnt_next  = (|cnt_mul[MUL_W-1:COUNT_BITS]) ? '1 : cnt_mul[COUNT_BITS-1:0];

	generate
		if (MAX_SYMBOL_CHARS >= 3) begin : g_name_wide
			assign name_out = sym_cur[SYM_W-1 -: NAME_W];
		end else begin : g_name_narrow
			assign name_out = NAME_W'(sym_cur);
		end
	endgenerate

	assign tok_cnt = tok_use_acc ? cnt_cur : COUNT_BITS'(1);

	always_comb begin
		phase_d     = phase_cur;
		sym_d       = sym_cur;
		len_d       = len_cur;
		cnt_d       = cnt_cur;
		emit_tok    = 1'b0;
		emit_err    = 1'b0;
		tok_use_acc = 1'b0;
		case (phase_cur)
			PH_IDLE: begin
				if (upper) begin
					phase_d = PH_SYM;
					sym_d   = sym_start;
					len_d   = LEN_W'(1);
					cnt_d   = '0;
				end else if (!sep) begin
					emit_err = 1'b1;
				end
			end
			PH_SYM: begin
				if (upper) begin
					emit_tok = 1'b1;
					phase_d  = PH_SYM;
					sym_d    = sym_start;
					len_d    = LEN_W'(1);
					cnt_d    = '0;
				end else if (lower) begin
					if (len_cur >= LEN_W'(MAX_SYMBOL_CHARS)) begin
						emit_err = 1'b1;
					end else begin
						sym_d = sym_ext;
						len_d = LEN_W'(len_cur + 1'b1);
					end
				end else if (digit) begin
					cnt_d   = digit_val;
					phase_d = PH_CNT;
				end else if (sep) begin
					emit_tok = 1'b1;
					phase_d  = PH_IDLE;
				end else begin
					emit_err = 1'b1;
				end
			end
			PH_CNT: begin
				if (upper) begin
					emit_tok    = 1'b1;
					tok_use_acc = 1'b1;
					phase_d     = PH_SYM;
					sym_d       = sym_start;
					len_d       = LEN_W'(1);
					cnt_d       = '0;
				end else if (digit) begin
					cnt_d = cnt_next;
				end else if (sep) begin
					emit_tok    = 1'b1;
					tok_use_acc = 1'b1;
					phase_d     = PH_IDLE;
					cnt_d       = '0;
				end else begin
					emit_err = 1'b1;
				end
			end
			PH_ERR: begin
				phase_d = PH_ERR;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (emit_err) begin
			phase_d = PH_ERR;
		end
	end

	assign res_valid = emit_tok || emit_err;

	always_comb begin
		if (emit_err) begin
			res.status       = STATUS_ERROR;
			res.element_name = '0;
			res.name_length  = '0;
			res.atom_count   = '0;
			res.bad_char     = c;
		end else begin
			res.status       = STATUS_TOKEN;
			res.element_name = name_out;
			res.name_length  = NAME_LEN_W'(len_cur);
			res.atom_count   = ATOM_W'(tok_cnt);
			res.bad_char     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sym_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			sym_q   <= sym_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end
endmodule

// ===== rtl/core/cft_out_stage.sv =====
// Result register stage driving the token output channel.
module cft_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             res_valid,
	input  cft_pkg::result_t res,
	output logic             free,
	cft_out_if.source        out
);
	import cft_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign free = !valid_s2 || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out.valid        = valid_s2;
	assign out.status       = res_s2.status;
	assign out.element_name = res_s2.element_name;
	assign out.name_length  = res_s2.name_length;
	assign out.atom_count   = res_s2.atom_count;
	assign out.bad_char     = res_s2.bad_char;
endmodule

// ===== rtl/core/chemical_formula_tokenizer.sv =====
// Top level of the chemical formula tokenizer.
//
// channel  dir  payload                                                   transfer
// in       in   char_code, first_of_formula                               valid && ready
// out      out  status, element_name, name_length, atom_count, bad_char   valid && ready
//
// One character per cycle unless out stalls; each token is registered in the output stage.
// Throughput is set by the parser state register, updated once per character.
// arst_n clears the parser to idle and empties both register stages.
// A stalled out holds its result; in keeps taking characters while the input stage can drain.
module chemical_formula_tokenizer #(
	parameter int MAX_SYMBOL_CHARS = cft_pkg::CFT_MAX_SYMBOL_CHARS,
	parameter int COUNT_BITS       = cft_pkg::CFT_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	cft_in_if.sink    in,
	cft_out_if.source out
);
	import cft_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    out_free;
	logic    res_valid;
	result_t res;

	assign advance = valid_s1 && out_free;

	cft_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cft_parse_core #(
		.MAX_SYMBOL_CHARS (MAX_SYMBOL_CHARS),
		.COUNT_BITS       (COUNT_BITS)
	) u_parse_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	cft_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.free      (out_free),
		.out       (out)
	);
endmodule

// ===== rtl/core/cft_checker.sv =====
// Port-level checks of the formula tokenizer, bound to the top level.
`include "chemical_formula_tokenizer_defines.svh"

module cft_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_status,
	input logic [cft_pkg::NAME_W-1:0]     out_element_name,
	input logic [cft_pkg::NAME_LEN_W-1:0] out_name_length,
	input logic [cft_pkg::ATOM_W-1:0]     out_atom_count,
	input logic [cft_pkg::CHAR_W-1:0]     out_bad_char
);
	import cft_pkg::*;

	`CFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_element_name) && $stable(out_atom_count) && $stable(out_bad_char))
	`CFT_ASSERT_SAME(a_err_fields, out_valid && (out_status == STATUS_ERROR), (out_element_name == '0) && (out_name_length == '0) && (out_atom_count == '0))
	`CFT_ASSERT_SAME(a_tok_fields, out_valid && (out_status == STATUS_TOKEN), out_bad_char == '0)
	`CFT_ASSERT_SAME(a_err_class, out_valid && (out_status == STATUS_ERROR), !is_upper(out_bad_char) && !is_sep(out_bad_char))
endmodule

bind chemical_formula_tokenizer cft_checker u_cft_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out.valid),
	.out_ready        (out.ready),
	.out_status       (out.status),
	.out_element_name (out.element_name),
	.out_name_length  (out.name_length),
	.out_atom_count   (out.atom_count),
	.out_bad_char     (out.bad_char)
);
